/* src/pmsm_pkg.sv */
// Shared types, constants and helpers for the PMSM phase-current RK4 stepper.
// Used by pmsm_lane and pmsm_phase_current_rk4_step; no dependencies.
`default_nettype none
package pmsm_pkg;

    localparam int PHASES = 3;

    // Sine polynomial coefficients, Q2.30
    localparam logic [31:0] SIN_A = 32'd1686629713;
    localparam logic [31:0] SIN_B = 32'd688904866;
    localparam logic [31:0] SIN_C = 32'd76016977;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] THIRD_TURN = 32'h5555_5555;
    // One sixth scaled by 2^14; exact quotient for dividends below 1536
    localparam logic [11:0] AVG_RECIP = 12'd2731;

    // Register map indexes
    localparam logic [2:0] REG_RESISTANCE = 3'd0;
    localparam logic [2:0] REG_BACK_EMF   = 3'd1;
    localparam logic [2:0] REG_SPEED      = 3'd2;
    localparam logic [2:0] REG_IND_A      = 3'd3;
    localparam logic [2:0] REG_IND_B      = 3'd4;
    localparam logic [2:0] REG_IND_C      = 3'd5;
    localparam logic [2:0] REG_TIME_STEP  = 3'd6;
    localparam logic [2:0] REG_FREQUENCY  = 3'd7;

    // Register reset values
    localparam logic [30:0] RST_RESISTANCE = 31'd65536;
    localparam logic [30:0] RST_BACK_EMF   = 31'd65536;
    localparam logic [31:0] RST_INDUCTANCE = 32'd268435;
    localparam logic [31:0] RST_TIME_STEP  = 32'd429497;
    localparam logic [15:0] RST_FREQUENCY  = 16'd600;

    // Motor settings shared by every lane
    typedef struct packed {
        logic [30:0]        resistance;
        logic [30:0]        back_emf;
        logic signed [31:0] speed;
        logic [31:0]        time_step;
    } motor_cfg_t;

    // Lane report to the merging stage
    typedef struct packed {
        logic               done;
        logic               clip;
        logic signed [31:0] current;
    } lane_stat_t;

    // Saturate to signed 32 bits; bit 32 flags a clip
    function automatic logic [32:0] sat32(input logic signed [64:0] x);
        logic [32:0] r;
        if (x > 65'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -65'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/pmsm_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on nothing; used by pmsm_lane for the step increments over the inductance.
`default_nettype none
module pmsm_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    // One restoring step
    always_comb begin
        shifted = {rem_reg, quo_reg[63]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    // Sequence the iterations
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[31:0] : shifted[31:0];
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* src/pmsm_lane.sv */
// One phase lane: sine, back-EMF and the four RK4 increments on a shared multiplier.
// Depends on pmsm_pkg and pmsm_div; holds the phase current state.
`default_nettype none
module pmsm_lane
    import pmsm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [31:0]        theta,
    input  wire logic signed [31:0] voltage,
    input  wire motor_cfg_t         cfg,
    input  wire logic [31:0]        inductance,
    output lane_stat_t              stat
);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_SQ    = 18'h00002,
        ST_S1    = 18'h00004,
        ST_S2    = 18'h00008,
        ST_S3    = 18'h00010,
        ST_MAG   = 18'h00020,
        ST_P     = 18'h00040,
        ST_Q     = 18'h00080,
        ST_EMF   = 18'h00100,
        ST_RMUL  = 18'h00200,
        ST_NCALC = 18'h00400,
        ST_NMUL  = 18'h00800,
        ST_DIVGO = 18'h01000,
        ST_DIVW  = 18'h02000,
        ST_UPD   = 18'h04000,
        ST_AVG   = 18'h08000,
        ST_DIV6  = 18'h10000,
        ST_FIN   = 18'h20000
    } lane_state_t;

    lane_state_t state_reg, state_next;
    logic [31:0]        th_reg, th_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] i0_reg, i0_next;
    logic signed [31:0] cur_reg, cur_next;
    logic [30:0]        x_reg, x_next;
    logic [31:0]        x2_reg, x2_next;
    logic [31:0]        sm_reg, sm_next;
    logic               sneg_reg, sneg_next;
    logic [62:0]        mag_reg, mag_next;
    logic [63:0]        p_reg, p_next;
    logic signed [49:0] e_reg, e_next;
    logic signed [31:0] n_reg, n_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               avg_neg_reg, avg_neg_next;
    logic [63:0]        avg_val_reg, avg_val_next;
    logic [63:0]        avg_q_reg, avg_q_next;
    logic [2:0]         avg_rem_reg, avg_rem_next;
    logic [2:0]         avg_cnt_reg, avg_cnt_next;
    logic [2:0]         stage_reg, stage_next;
    logic               clip_reg, clip_next;
    logic               done_reg, done_next;
    logic [63:0]        prod_reg;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod_comb;
    logic [30:0]        u;
    logic [30:0]        x;
    logic [31:0]        tsub;
    logic [31:0]        wm;
    logic [31:0]        cur_abs;
    logic [31:0]        n_abs;
    logic [64:0]        lowsum;
    logic [63:0]        r;
    logic [64:0]        rt_s;
    logic signed [64:0] n_full;
    logic [32:0]        sat_n;
    logic [63:0]        k;
    logic [63:0]        half;
    logic [63:0]        kadd;
    logic [32:0]        sat_t;
    logic [10:0]        avg_v6;
    logic [22:0]        avg_prod;
    logic [7:0]         avg_q6;
    logic [10:0]        avg_r6;
    logic [63:0]        qa;
    logic [32:0]        sat_f;
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [63:0]        div_q;

    pmsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Datapath terms
    always_comb begin
        u       = {1'b0, th_reg[29:0]};
        x       = th_reg[30] ? (ONE_Q30 - u) : u;
        tsub    = ((state_reg == ST_S2) ? SIN_B : SIN_A) - prod_reg[61:30];
        wm      = cfg.speed[31] ? (~cfg.speed + 32'd1) : cfg.speed;
        cur_abs = cur_reg[31] ? (~cur_reg + 32'd1) : cur_reg;
        n_abs   = n_reg[31] ? (~n_reg + 32'd1) : n_reg;
        // back-EMF magnitude: floor(mag * s / 2^46) from the split products
        lowsum  = {19'b0, p_reg[14:0], 31'b0} + {1'b0, prod_reg};
        r       = {15'b0, p_reg[63:15]} + {45'b0, lowsum[64:46]};
        // resistive drop, truncated toward zero
        rt_s    = cur_reg[31] ? (65'd0 - {17'b0, prod_reg[63:16]}) : {17'b0, prod_reg[63:16]};
        n_full  = $signed({{33{v_reg[31]}}, v_reg}) - $signed(rt_s)
                  - $signed({{15{e_reg[49]}}, e_reg});
        sat_n   = sat32(n_full);
        // signed increment and trial current
        k       = n_reg[31] ? (64'd0 - div_q) : div_q;
        half    = {k[63], k[63:1]} + {63'b0, k[63] & k[0]};
        kadd    = (stage_reg == 3'd2) ? k : half;
        sat_t   = sat32($signed({{33{i0_reg[31]}}, i0_reg}) + $signed({kadd[63], kadd}));
        // divide by six one byte at a time: remainder below six carries to the next byte
        avg_v6   = {avg_rem_reg, avg_val_reg[63:56]};
        avg_prod = {12'b0, avg_v6} * {11'b0, AVG_RECIP};
        avg_q6   = avg_prod[21:14];
        // remainder = v - 6q
        avg_r6   = avg_v6 - ({1'b0, avg_q6, 2'b0} + {2'b0, avg_q6, 1'b0});
        qa      = avg_neg_reg ? (64'd0 - avg_q_reg) : avg_q_reg;
        sat_f   = sat32($signed({{33{i0_reg[31]}}, i0_reg}) + $signed({qa[63], qa}));
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ: begin
                mul_a = {1'b0, x};
                mul_b = {1'b0, x};
            end
            ST_S1: begin
                mul_a = SIN_C;
                mul_b = prod_reg[61:30];
            end
            ST_S2: begin
                mul_a = tsub;
                mul_b = x2_reg;
            end
            ST_S3: begin
                mul_a = tsub;
                mul_b = {1'b0, x_reg};
            end
            ST_MAG: begin
                mul_a = {1'b0, cfg.back_emf};
                mul_b = wm;
            end
            ST_P: begin
                mul_a = prod_reg[62:31];
                mul_b = sm_reg;
            end
            ST_Q: begin
                mul_a = {1'b0, mag_reg[30:0]};
                mul_b = sm_reg;
            end
            ST_RMUL: begin
                mul_a = cur_abs;
                mul_b = {1'b0, cfg.resistance};
            end
            ST_NMUL: begin
                mul_a = n_abs;
                mul_b = cfg.time_step;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_comb = mul_a * mul_b;
    end

    // Divider feed
    always_comb begin
        div_start    = (state_reg == ST_DIVGO);
        div_dividend = {4'b0, prod_reg[63:4]};
        div_divisor  = (inductance == 32'd0) ? 32'd1 : inductance;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        th_next      = th_reg;
        v_next       = v_reg;
        i0_next      = i0_reg;
        cur_next     = cur_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        sm_next      = sm_reg;
        sneg_next    = sneg_reg;
        mag_next     = mag_reg;
        p_next       = p_reg;
        e_next       = e_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        avg_neg_next = avg_neg_reg;
        avg_val_next = avg_val_reg;
        avg_q_next   = avg_q_reg;
        avg_rem_next = avg_rem_reg;
        avg_cnt_next = avg_cnt_reg;
        stage_next   = stage_reg;
        clip_next    = clip_reg;
        done_next    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    th_next    = theta;
                    v_next     = voltage;
                    clip_next  = 1'b0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                x_next     = x;
                state_next = ST_S1;
            end
            ST_S1: begin
                x2_next    = prod_reg[61:30];
                state_next = ST_S2;
            end
            ST_S2: state_next = ST_S3;
            ST_S3: state_next = ST_MAG;
            ST_MAG: begin
                sm_next    = prod_reg[61:30];
                sneg_next  = th_reg[31];
                state_next = ST_P;
            end
            ST_P: begin
                mag_next   = prod_reg[62:0];
                state_next = ST_Q;
            end
            ST_Q: begin
                p_next     = prod_reg;
                state_next = ST_EMF;
            end
            ST_EMF: begin
                e_next     = (sneg_reg ^ cfg.speed[31]) ? (50'd0 - r[49:0]) : r[49:0];
                cur_next   = i0_reg;
                stage_next = '0;
                acc_next   = '0;
                state_next = ST_RMUL;
            end
            ST_RMUL: state_next = ST_NCALC;
            ST_NCALC: begin
                n_next     = sat_n[31:0];
                state_next = ST_NMUL;
            end
            ST_NMUL: state_next = ST_DIVGO;
            ST_DIVGO: state_next = ST_DIVW;
            ST_DIVW: begin
                if (div_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                // accumulate k1 + 2*k2 + 2*k3 + k4
                if (stage_reg == 3'd0) begin
                    acc_next = k;
                end else if (stage_reg == 3'd3) begin
                    acc_next = acc_reg + k;
                end else begin
                    acc_next = acc_reg + {k[62:0], 1'b0};
                end
                stage_next = stage_reg + 3'd1;
                if (stage_reg == 3'd3) begin
                    state_next = ST_AVG;
                end else begin
                    cur_next   = sat_t[31:0];
                    clip_next  = clip_reg | sat_t[32];
                    state_next = ST_RMUL;
                end
            end
            ST_AVG: begin
                avg_neg_next = acc_reg[63];
                avg_val_next = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
                avg_q_next   = '0;
                avg_rem_next = '0;
                avg_cnt_next = '0;
                state_next   = ST_DIV6;
            end
            ST_DIV6: begin
                avg_q_next   = {avg_q_reg[55:0], avg_q6};
                avg_val_next = {avg_val_reg[55:0], 8'b0};
                avg_rem_next = avg_r6[2:0];
                avg_cnt_next = avg_cnt_reg + 3'd1;
                if (avg_cnt_reg == 3'd7) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                i0_next    = sat_f[31:0];
                clip_next  = clip_reg | sat_f[32];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i0_reg    <= '0;
            done_reg  <= 1'b0;
            clip_reg  <= 1'b0;
            stage_reg <= '0;
        end else begin
            state_reg <= state_next;
            i0_reg    <= i0_next;
            done_reg  <= done_next;
            clip_reg  <= clip_next;
            stage_reg <= stage_next;
        end
        th_reg      <= th_next;
        v_reg       <= v_next;
        cur_reg     <= cur_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        sm_reg      <= sm_next;
        sneg_reg    <= sneg_next;
        mag_reg     <= mag_next;
        p_reg       <= p_next;
        e_reg       <= e_next;
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        avg_neg_reg <= avg_neg_next;
        avg_val_reg <= avg_val_next;
        avg_q_reg   <= avg_q_next;
        avg_rem_reg <= avg_rem_next;
        avg_cnt_reg <= avg_cnt_next;
        prod_reg    <= prod_comb;
    end

    assign stat.done    = done_reg;
    assign stat.clip    = clip_reg;
    assign stat.current = i0_reg;

endmodule
`default_nettype wire

/* src/pmsm_phase_current_rk4_step.sv */
// Each input transaction runs through sine and back-EMF, four RK4 increments (each with
// a bit-serial division by the inductance), the byte-wise divide by six of the RK4 sum
// and merging before the result is valid. The three phase lanes run in parallel; the next
// input is taken only once the previous result is in the output register, waiting there.
// Reset (synchronous, active-low aresetn): currents and rotor angle clear to zero,
// registers take their documented defaults. Depends on pmsm_pkg and pmsm_lane.
`default_nettype none
module pmsm_phase_current_rk4_step
    import pmsm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_voltage_a,
    input  wire logic signed [31:0] s_voltage_b,
    input  wire logic signed [31:0] s_voltage_c,
    input  wire logic [63:0]        s_sim_time,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_current_a,
    output logic signed [31:0]      m_current_b,
    output logic signed [31:0]      m_current_c,
    output logic [31:0]             m_angle_out,
    output logic                    m_saturated,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [30:0]        res_reg;
    logic [30:0]        kemf_reg;
    logic signed [31:0] speed_reg;
    logic [31:0]        ind_reg [PHASES];
    logic [31:0]        ts_reg;
    logic [15:0]        freq_reg;

    logic               busy_reg, busy_next;
    logic [PHASES-1:0]  mask_reg, mask_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        rotor_reg, rotor_next;
    logic [31:0]        angle_new_reg, angle_new_next;
    logic signed [31:0] cur_out_reg [PHASES];
    logic [31:0]        angle_out_reg;
    logic               sat_out_reg;

    logic               accept;
    logic               load;
    logic               cfg_wr;
    motor_cfg_t         cfg;
    lane_stat_t         stat [PHASES];
    logic signed [31:0] volt [PHASES];
    logic [31:0]        offset [PHASES];
    logic [PHASES-1:0]  done_vec;
    logic [PHASES-1:0]  clip_vec;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg    <= RST_RESISTANCE;
            kemf_reg   <= RST_BACK_EMF;
            speed_reg  <= '0;
            ind_reg[0] <= RST_INDUCTANCE;
            ind_reg[1] <= RST_INDUCTANCE;
            ind_reg[2] <= RST_INDUCTANCE;
            ts_reg     <= RST_TIME_STEP;
            freq_reg   <= RST_FREQUENCY;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_RESISTANCE: res_reg    <= pwdata[30:0];
                REG_BACK_EMF:   kemf_reg   <= pwdata[30:0];
                REG_SPEED:      speed_reg  <= pwdata;
                REG_IND_A:      ind_reg[0] <= pwdata;
                REG_IND_B:      ind_reg[1] <= pwdata;
                REG_IND_C:      ind_reg[2] <= pwdata;
                REG_TIME_STEP:  ts_reg     <= pwdata;
                REG_FREQUENCY:  freq_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read
    always_comb begin
        case (paddr[4:2])
            REG_RESISTANCE: prdata = {1'b0, res_reg};
            REG_BACK_EMF:   prdata = {1'b0, kemf_reg};
            REG_SPEED:      prdata = speed_reg;
            REG_IND_A:      prdata = ind_reg[0];
            REG_IND_B:      prdata = ind_reg[1];
            REG_IND_C:      prdata = ind_reg[2];
            REG_TIME_STEP:  prdata = ts_reg;
            REG_FREQUENCY:  prdata = {16'b0, freq_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.resistance = res_reg;
    assign cfg.back_emf   = kemf_reg;
    assign cfg.speed      = speed_reg;
    assign cfg.time_step  = ts_reg;

    assign volt[0]   = s_voltage_a;
    assign volt[1]   = s_voltage_b;
    assign volt[2]   = s_voltage_c;
    assign offset[0] = 32'd0;
    assign offset[1] = 32'd0 - THIRD_TURN;
    assign offset[2] = THIRD_TURN;

    assign s_ready = !busy_reg;
    assign accept  = s_valid & !busy_reg;

    // Phase lanes
    for (genvar j = 0; j < PHASES; j++) begin : g_lane
        pmsm_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .start      (accept),
            .theta      (rotor_reg + offset[j]),
            .voltage    (volt[j]),
            .cfg        (cfg),
            .inductance (ind_reg[j]),
            .stat       (stat[j])
        );
        assign done_vec[j] = stat[j].done;
        assign clip_vec[j] = stat[j].clip;
    end

    // Merge lane results and hand off to the output register
    always_comb begin
        busy_next      = busy_reg;
        mask_next      = mask_reg | done_vec;
        rotor_next     = rotor_reg;
        angle_new_next = angle_new_reg;
        m_valid_next   = m_valid_reg & !m_ready;
        load           = busy_reg && (&mask_reg) && (!m_valid_reg || m_ready);
        if (accept) begin
            busy_next      = 1'b1;
            mask_next      = '0;
            angle_new_next = s_sim_time[31:0] * {16'b0, freq_reg};
        end
        if (load) begin
            busy_next    = 1'b0;
            mask_next    = '0;
            rotor_next   = angle_new_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
            rotor_reg   <= '0;
        end else begin
            busy_reg    <= busy_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
            rotor_reg   <= rotor_next;
        end
        angle_new_reg <= angle_new_next;
        if (load) begin
            cur_out_reg[0] <= stat[0].current;
            cur_out_reg[1] <= stat[1].current;
            cur_out_reg[2] <= stat[2].current;
            angle_out_reg  <= angle_new_reg;
            sat_out_reg    <= |clip_vec;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_current_a = cur_out_reg[0];
    assign m_current_b = cur_out_reg[1];
    assign m_current_c = cur_out_reg[2];
    assign m_angle_out = angle_out_reg;
    assign m_saturated = sat_out_reg;

endmodule
`default_nettype wire
